### hdl/frlt_pkg.sv
// ----------------------------------------------------------------------------
// frlt_pkg
// Shared types and constants of the failure rate lockout table.
// ----------------------------------------------------------------------------
package frlt_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;
	localparam int MAX_STAMPS_DEF    = 16;

	localparam logic [15:0] WINDOW_RESET    = 16'd300;
	localparam logic [4:0]  THRESHOLD_RESET = 5'd5;
	localparam logic [15:0] LOCKOUT_RESET   = 16'd900;

	localparam logic [1:0] CMD_CHECK   = 2'd0;
	localparam logic [1:0] CMD_FAILURE = 2'd1;
	localparam logic [1:0] CMD_SUCCESS = 2'd2;

	localparam logic [1:0] REG_WINDOW    = 2'd0;
	localparam logic [1:0] REG_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_LOCKOUT   = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] client_key;
		logic [31:0] now_seconds;
	} in_item_t;

	typedef struct packed {
		logic        lock_flag;
		logic [15:0] retry_after;
		logic        table_full;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;        // capture input item, start search at entry 0
		logic scan_step;   // compare one table entry, advance
		logic read_entry;  // fetch entry state of the found/free entry
		logic read_stamp;  // read oldest stamp from memory
		logic pop_stamp;   // drop the oldest stamp
		logic clear_lock;  // wipe expired lockout and stamps
		logic alloc;       // take the free entry for a new client
		logic append;      // append now and maybe lock out
		logic release_e;   // free the entry
		logic result;      // present result
	} frlt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] cmd;
		logic       scan_done;
		logic       found;
		logic       have_free;
		logic       locked;
		logic       lock_pending;
		logic       ring_empty;
		logic       stale;
	} frlt_stat_t;

endpackage

### hdl/failure_rate_lockout_table.sv
// ----------------------------------------------------------------------------
// failure_rate_lockout_table
// Sliding-window failure rate limiter over a table of clients.
// ----------------------------------------------------------------------------
// A command passes through the key search, which visits one table entry per
// cycle, then fetch, decide, stamp read, test, append, result and output, as
// far as the command needs them; each stale stamp dropped costs another stamp
// read and test, since stale stamps come out of the single-port stamp memory
// one at a time. A check that finds a locked client skips the stamp work.
// The next command is taken in the cycle its
// predecessor's result is transferred out, or later.
module failure_rate_lockout_table #(
	parameter int TABLE_ENTRIES = frlt_pkg::TABLE_ENTRIES_DEF,
	parameter int MAX_STAMPS    = frlt_pkg::MAX_STAMPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  frlt_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output frlt_pkg::out_item_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import frlt_pkg::*;

	logic [15:0] window_q;
	logic [4:0]  threshold_q;
	logic [15:0] lockout_q;
	frlt_cmd_t   ctl;
	frlt_stat_t  stat;
	logic [1:0]  reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WINDOW_RESET;
			threshold_q <= THRESHOLD_RESET;
			lockout_q   <= LOCKOUT_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_WINDOW:    window_q    <= pwdata[15:0];
				REG_THRESHOLD: threshold_q <= pwdata[4:0];
				REG_LOCKOUT:   lockout_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (reg_idx)
			REG_WINDOW:    prdata = {16'd0, window_q};
			REG_THRESHOLD: prdata = {27'd0, threshold_q};
			REG_LOCKOUT:   prdata = {16'd0, lockout_q};
			default:       prdata = '0;
		endcase
	end

	frlt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	frlt_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.MAX_STAMPS    (MAX_STAMPS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.item            (in_data),
		.window_cfg      (window_q),
		.fail_threshold  (threshold_q),
		.lockout_cfg     (lockout_q),
		.ctl             (ctl),
		.stat            (stat),
		.result          (out_data)
	);

endmodule

### hdl/frlt_datapath.sv
// ----------------------------------------------------------------------------
// frlt_datapath
// Client table, stamp memory and the arithmetic of one command.
// ----------------------------------------------------------------------------
module frlt_datapath #(
	parameter int TABLE_ENTRIES = frlt_pkg::TABLE_ENTRIES_DEF,
	parameter int MAX_STAMPS    = frlt_pkg::MAX_STAMPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  frlt_pkg::in_item_t  item,
	input  logic [15:0]         window_cfg,
	input  logic [4:0]          fail_threshold,
	input  logic [15:0]         lockout_cfg,
	input  frlt_pkg::frlt_cmd_t ctl,
	output frlt_pkg::frlt_stat_t stat,
	output frlt_pkg::out_item_t result
);
	import frlt_pkg::*;

	localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int SW = (MAX_STAMPS > 1) ? $clog2(MAX_STAMPS) : 1;
	localparam int CW = $clog2(MAX_STAMPS + 1);
	localparam int MW = EW + SW;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int STAMP_DEPTH = TABLE_ENTRIES * (1 << SW);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_STAMPS);

	// entry state
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [31:0] key_mem   [TABLE_ENTRIES];
	logic [31:0] dl_mem    [TABLE_ENTRIES];
	logic [SW-1:0] head_mem [TABLE_ENTRIES];
	logic [CW-1:0] cnt_mem  [TABLE_ENTRIES];
	logic [31:0] stamp_mem [STAMP_DEPTH];

	// working registers
	in_item_t      item_q;
	logic [CNT_W-1:0] scan_q;
	logic          found_q;
	logic          free_ok_q;
	logic [EW-1:0] hit_q;
	logic [EW-1:0] free_q;
	logic [31:0]   dl_q;
	logic [SW-1:0] head_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   stamp_q;
	out_item_t     res_q;

	logic [EW-1:0] scan_idx;
	logic [EW-1:0] ent;
	logic [31:0]   diff;
	logic          stale;
	logic          locked;
	logic [SW-1:0] head_app;
	logic [CW-1:0] cnt_app;
	logic [SW-1:0] wr_slot;
	logic [CW:0]   slot_sum;
	logic [32:0]   dl_sum;
	logic [31:0]   dl_new;
	logic [31:0]   rem;

	assign scan_idx = scan_q[EW-1:0];
	assign ent      = found_q ? hit_q : free_q;
	assign diff     = item_q.now_seconds - stamp_q;
	assign stale    = (item_q.now_seconds > stamp_q) && (diff > {16'd0, window_cfg});
	assign locked   = dl_q > item_q.now_seconds;
	assign rem      = dl_q - item_q.now_seconds;

	// full ring drops its oldest stamp before the append
	always_comb begin
		head_app = head_q;
		cnt_app  = cnt_q;
		if (cnt_q >= MAX_CNT) begin
			head_app = (head_q == SW'(MAX_STAMPS - 1)) ? '0 : head_q + 1'b1;
			cnt_app  = MAX_CNT - 1'b1;
		end
		slot_sum = {1'b0, CW'(head_app)} + {1'b0, cnt_app};
		if (slot_sum >= (CW+1)'(MAX_STAMPS))
			slot_sum = slot_sum - (CW+1)'(MAX_STAMPS);
		wr_slot = slot_sum[SW-1:0];
		dl_sum  = {1'b0, item_q.now_seconds} + {17'd0, lockout_cfg};
		dl_new  = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];
	end

	assign stat.cmd          = item_q.cmd;
	assign stat.scan_done    = (scan_q == CNT_W'(TABLE_ENTRIES)) || found_q;
	assign stat.found        = found_q;
	assign stat.have_free    = free_ok_q;
	assign stat.locked       = locked;
	assign stat.lock_pending = dl_q != 32'd0;
	assign stat.ring_empty   = cnt_q == '0;
	assign stat.stale        = stale;
	assign result            = res_q;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.alloc) begin
			valid_q[free_q] <= 1'b1;
		end else if (ctl.release_e) begin
			valid_q[hit_q] <= 1'b0;
		end
	end

	// one table entry per cycle in the search
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q    <= item;
			scan_q    <= '0;
			found_q   <= 1'b0;
			free_ok_q <= 1'b0;
			free_q    <= '0;
			hit_q     <= '0;
		end else if (ctl.scan_step) begin
			if (valid_q[scan_idx] && key_mem[scan_idx] == item_q.client_key) begin
				found_q <= 1'b1;
				hit_q   <= scan_idx;
			end else if (!valid_q[scan_idx] && !free_ok_q) begin
				free_ok_q <= 1'b1;
				free_q    <= scan_idx;
			end
			scan_q <= scan_q + 1'b1;
		end
	end

	// entry fields and stamp memory
	always_ff @(posedge clk) begin
		if (ctl.read_entry) begin
			dl_q   <= dl_mem[ent];
			head_q <= head_mem[ent];
			cnt_q  <= cnt_mem[ent];
		end
		if (ctl.read_stamp)
			stamp_q <= stamp_mem[{ent, head_q}];
		if (ctl.pop_stamp) begin
			head_q <= (head_q == SW'(MAX_STAMPS - 1)) ? '0 : head_q + 1'b1;
			cnt_q  <= cnt_q - 1'b1;
			head_mem[ent] <= (head_q == SW'(MAX_STAMPS - 1)) ? '0 : head_q + 1'b1;
			cnt_mem[ent]  <= cnt_q - 1'b1;
		end
		if (ctl.clear_lock) begin
			dl_q <= '0;
			head_q <= '0;
			cnt_q <= '0;
			dl_mem[ent] <= '0;
			head_mem[ent] <= '0;
			cnt_mem[ent] <= '0;
		end
		if (ctl.alloc) begin
			key_mem[free_q]  <= item_q.client_key;
			dl_mem[free_q]   <= '0;
			head_mem[free_q] <= '0;
			cnt_mem[free_q]  <= '0;
			dl_q   <= '0;
			head_q <= '0;
			cnt_q  <= '0;
		end
		if (ctl.append) begin
			stamp_mem[MW'({ent, wr_slot})] <= item_q.now_seconds;
			head_mem[ent] <= head_app;
			cnt_mem[ent]  <= cnt_app + 1'b1;
			if ({{(32-CW){1'b0}}, cnt_app + 1'b1} >= {27'd0, fail_threshold})
				dl_mem[ent] <= dl_new;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			res_q <= '0;
		end else if (ctl.result) begin
			res_q <= '0;
			if (item_q.cmd == CMD_CHECK && found_q && locked) begin
				res_q.lock_flag   <= 1'b1;
				res_q.retry_after <= (rem > 32'h0000_FFFF) ? 16'hFFFF : rem[15:0];
			end
			if (item_q.cmd == CMD_FAILURE && !found_q && !free_ok_q)
				res_q.table_full <= 1'b1;
		end
	end

endmodule

### hdl/frlt_ctrl.sv
// ----------------------------------------------------------------------------
// frlt_ctrl
// Sequencer for one command: search, fetch, pop stale stamps, update, reply.
// ----------------------------------------------------------------------------
module frlt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  frlt_pkg::frlt_stat_t stat,
	output frlt_pkg::frlt_cmd_t  ctl
);
	import frlt_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_SCAN  = 9'b000000010,
		ST_FETCH = 9'b000000100,
		ST_DECIDE= 9'b000001000,
		ST_RDSTP = 9'b000010000,
		ST_TEST  = 9'b000100000,
		ST_APPEND= 9'b001000000,
		ST_RESULT= 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   out_busy_q;

	// input enters once the previous result is gone or leaves in the same cycle
	assign in_stall  = (state_q != ST_IDLE) || (out_busy_q && out_stall);
	assign out_valid = out_busy_q;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && !in_stall) begin
					ctl.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.scan_done) begin
					state_d = ST_FETCH;
				end else begin
					ctl.scan_step = 1'b1;
				end
			end
			ST_FETCH: begin
				if (stat.cmd == CMD_FAILURE && !stat.found && stat.have_free) begin
					ctl.alloc = 1'b1;
					state_d   = ST_RDSTP;
				end else if (!stat.found) begin
					state_d = ST_RESULT;
				end else if (stat.cmd == CMD_SUCCESS) begin
					ctl.release_e = 1'b1;
					state_d       = ST_RESULT;
				end else if (stat.cmd == CMD_CHECK || stat.cmd == CMD_FAILURE) begin
					ctl.read_entry = 1'b1;
					state_d        = ST_DECIDE;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_DECIDE: begin
				if (stat.cmd == CMD_CHECK && stat.locked) begin
					state_d = ST_RESULT;
				end else begin
					if (stat.cmd == CMD_CHECK && stat.lock_pending)
						ctl.clear_lock = 1'b1;
					state_d = ST_RDSTP;
				end
			end
			ST_RDSTP: begin
				ctl.read_stamp = 1'b1;
				state_d        = ST_TEST;
			end
			ST_TEST: begin
				if (!stat.ring_empty && stat.stale) begin
					ctl.pop_stamp = 1'b1;
					state_d       = ST_RDSTP;
				end else if (stat.cmd == CMD_FAILURE) begin
					state_d = ST_APPEND;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_APPEND: begin
				ctl.append = 1'b1;
				state_d    = ST_RESULT;
			end
			ST_RESULT: begin
				ctl.result = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (!out_busy_q || !out_stall)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and output holding flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			out_busy_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT && state_d == ST_IDLE)
				out_busy_q <= 1'b1;
			else if (out_busy_q && !out_stall)
				out_busy_q <= 1'b0;
		end
	end

endmodule

### sim/failure_rate_lockout_table_tb.sv
// ----------------------------------------------------------------------------
// failure_rate_lockout_table_tb
// Self-checking bench for the failure rate lockout table. A cycle-free model
// of the client table predicts every result. Commands arrive with random
// gaps, results are taken under random stall, and the settings are changed
// between phases over an APB-style register port.
// ----------------------------------------------------------------------------
module failure_rate_lockout_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import frlt_pkg::*;

	localparam int          N_ENTRIES   = TABLE_ENTRIES_DEF;
	localparam int          N_STAMPS    = MAX_STAMPS_DEF;
	localparam logic [1:0]  CMD_UNUSED  = 2'd3;
	localparam int          SETTLE      = 120;
	localparam int          EXP_DEPTH   = 64;
	localparam longint      CYCLE_LIMIT = 900000;

	// lockout table predictor with its own copy of state and settings
	class lockout_scoreboard;
		logic [15:0] window;
		logic [4:0]  threshold;
		logic [15:0] lockout;
		bit          valid [N_ENTRIES];
		logic [31:0] key [N_ENTRIES];
		logic [31:0] deadline [N_ENTRIES];
		logic [31:0] stamps [N_ENTRIES][N_STAMPS];
		int          head [N_ENTRIES];
		int          count [N_ENTRIES];
		out_item_t   exp_mem [EXP_DEPTH];
		int          wr_idx;
		int          rd_idx;
		int          errors;

		function void clear();
			window = WINDOW_RESET;
			threshold = THRESHOLD_RESET;
			lockout = LOCKOUT_RESET;
			foreach (valid[i]) begin
				valid[i] = 0;
				key[i] = '0;
				deadline[i] = '0;
				head[i] = 0;
				count[i] = 0;
			end
			wr_idx = 0;
			rd_idx = 0;
			errors = 0;
		endfunction

		// results still owed by the block
		function int pending();
			return wr_idx - rd_idx;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_WINDOW:    window = value[15:0];
				REG_THRESHOLD: threshold = value[4:0];
				REG_LOCKOUT:   lockout = value[15:0];
				default: ;
			endcase
		endfunction

		// pop stamps that fell out of the window
		function void drop_stale(int e, logic [31:0] now);
			logic [31:0] s;
			while (count[e] > 0) begin
				s = stamps[e][head[e]];
				if (!(now > s && (now - s) > {16'd0, window}))
					break;
				head[e] = (head[e] + 1) % N_STAMPS;
				count[e]--;
			end
		endfunction

		function void note_input(in_item_t it);
			out_item_t r;
			int e;
			logic [31:0] rem;
			logic [32:0] sum;
			r = '0;
			e = -1;
			for (int i = 0; i < N_ENTRIES; i++)
				if (e < 0 && valid[i] && key[i] == it.client_key)
					e = i;
			case (it.cmd)
				CMD_CHECK: if (e >= 0) begin
					if (deadline[e] > it.now_seconds) begin
						rem = deadline[e] - it.now_seconds;
						r.lock_flag = 1'b1;
						r.retry_after = (rem > 32'hFFFF) ? 16'hFFFF : rem[15:0];
					end else begin
						if (deadline[e] != 0) begin
							deadline[e] = '0;
							count[e] = 0;
							head[e] = 0;
						end
						drop_stale(e, it.now_seconds);
					end
				end
				CMD_FAILURE: begin
					if (e < 0) begin
						for (int i = 0; i < N_ENTRIES; i++)
							if (e < 0 && !valid[i])
								e = i;
						if (e >= 0) begin
							valid[e] = 1;
							key[e] = it.client_key;
							deadline[e] = '0;
							head[e] = 0;
							count[e] = 0;
						end
					end
					if (e < 0) begin
						r.table_full = 1'b1;
					end else begin
						drop_stale(e, it.now_seconds);
						if (count[e] >= N_STAMPS) begin
							head[e] = (head[e] + 1) % N_STAMPS;
							count[e] = N_STAMPS - 1;
						end
						stamps[e][(head[e] + count[e]) % N_STAMPS] = it.now_seconds;
						count[e]++;
						if (count[e] >= threshold) begin
							sum = {1'b0, it.now_seconds} + {17'd0, lockout};
							deadline[e] = sum[32] ? 32'hFFFFFFFF : sum[31:0];
						end
					end
				end
				CMD_SUCCESS: if (e >= 0) valid[e] = 0;
				default: ;
			endcase
			exp_mem[wr_idx % EXP_DEPTH] = r;
			wr_idx++;
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp;
			if (pending() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			exp = exp_mem[rd_idx % EXP_DEPTH];
			rd_idx++;
			if (got.lock_flag !== exp.lock_flag) begin
				$display("%0t: lock_flag exp %b got %b", $time, exp.lock_flag, got.lock_flag);
				errors++;
			end
			if (got.retry_after !== exp.retry_after) begin
				$display("%0t: retry_after exp %0d got %0d", $time, exp.retry_after,
					got.retry_after);
				errors++;
			end
			if (got.table_full !== exp.table_full) begin
				$display("%0t: table_full exp %b got %b", $time, exp.table_full, got.table_full);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	lockout_scoreboard sb;
	longint      cycles;
	bit          hold_request;
	logic [31:0] key_pool [20];
	logic [31:0] sim_now;

	failure_rate_lockout_table dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// clock
	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// result checking
	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);

	// receiver stall, with one long hold-off on request
	initial begin
		int hold;
		hold = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else if (hold_request) begin
				hold_request = 0;
				hold = 400;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 99) < 60) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 9) == 0) ? 1'b1 : ($urandom_range(0, 1) == 1);
				if ($urandom_range(0, 49) == 0)
					hold = $urandom_range(10, 40);
			end
		end
	end

	// one command transfer followed by a random gap
	task automatic send_cmd(logic [1:0] cmd, logic [31:0] client, logic [31:0] now,
			bit gaps);
		int gap;
		in_valid <= 1'b1;
		in_data <= '{cmd: cmd, client_key: client, now_seconds: now};
		do @(posedge clk); while (in_stall);
		sb.note_input(in_data);
		gap = 0;
		if (gaps && $urandom_range(0, 99) < 40)
			gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// wait for every outstanding result, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// APB write: setup cycle then access cycle, then the bus returns to idle
	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_all(logic [15:0] win, logic [4:0] thr, logic [15:0] lock);
		drain();
		write_reg(REG_WINDOW, {16'd0, win});
		write_reg(REG_THRESHOLD, {27'd0, thr});
		write_reg(REG_LOCKOUT, {16'd0, lock});
	endtask

	// random traffic: a small client pool so entries fill, lock and expire
	task automatic random_phase(int n, int hold_at);
		logic [1:0]  cmd;
		logic [31:0] client;
		int          p;
		for (int k = 0; k < n; k++) begin
			if (k == hold_at)
				hold_request = 1;
			p = $urandom_range(0, 99);
			if (p < 45)
				cmd = CMD_FAILURE;
			else if (p < 80)
				cmd = CMD_CHECK;
			else if (p < 95)
				cmd = CMD_SUCCESS;
			else
				cmd = CMD_UNUSED;
			client = ($urandom_range(0, 19) == 0) ? $urandom() : key_pool[$urandom_range(0, 19)];
			p = $urandom_range(0, 99);
			if (p < 70)
				sim_now = sim_now + $urandom_range(0, 30);
			else if (p < 85)
				sim_now = sim_now + $urandom_range(100, 2000);
			else if (p < 93)
				sim_now = sim_now - $urandom_range(1, 500);
			else if (p < 97)
				sim_now = 32'hFFFFFFFF - $urandom_range(0, 70000);
			else
				sim_now = $urandom();
			send_cmd(cmd, client, sim_now, 1);
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		hold_request = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		foreach (key_pool[i])
			key_pool[i] = $urandom();
		key_pool[0] = 32'h0;
		key_pool[1] = 32'hFFFFFFFF;
		sim_now = 32'd1000;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unknown clients, unused command, lockout and its expiry
		send_cmd(CMD_CHECK, 32'h0, 32'd10, 0);
		send_cmd(CMD_SUCCESS, 32'hFFFFFFFF, 32'd10, 0);
		send_cmd(CMD_UNUSED, 32'h0, 32'd10, 0);
		for (int k = 0; k < 5; k++)
			send_cmd(CMD_FAILURE, 32'h0, 32'd100 + k, 0);
		send_cmd(CMD_CHECK, 32'h0, 32'd200, 0);
		send_cmd(CMD_CHECK, 32'h0, 32'd0, 0);
		send_cmd(CMD_CHECK, 32'h0, 32'd2000, 0);
		// deadline saturation near the top of time
		for (int k = 0; k < 5; k++)
			send_cmd(CMD_FAILURE, 32'hFFFFFFFF, 32'hFFFFFF00, 0);
		send_cmd(CMD_CHECK, 32'hFFFFFFFF, 32'd5, 0);
		// fill the table with one new client too many, then free an entry for another client
		for (int k = 2; k < 17; k++)
			send_cmd(CMD_FAILURE, 32'h5A5A0000 + k, 32'd3000, 0);
		send_cmd(CMD_SUCCESS, 32'h5A5A0003, 32'd3001, 0);
		send_cmd(CMD_FAILURE, 32'hA5A5A5A5, 32'd3002, 0);

		random_phase(140, 40);
		// sender pauses until everything is back
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		random_phase(30, -1);

		set_all(16'd0, 5'd1, 16'd0);
		random_phase(120, -1);
		set_all(16'hFFFF, 5'd16, 16'hFFFF);
		random_phase(130, -1);
		set_all(16'd20, 5'd0, 16'd50);
		random_phase(100, -1);
		set_all(16'd5000, 5'd31, 16'd10);
		random_phase(100, -1);
		set_all(16'd60, 5'd3, 16'd400);
		random_phase(100, 50);
		set_all(16'($urandom()), 5'($urandom_range(1, 16)), 16'($urandom()));
		random_phase(100, -1);

		drain();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
